FILE: rtl/snd_pkg.sv
// Shared types, constants and helper functions for the sensor packet nibble decoder.
package snd_pkg;

   localparam logic [3:0]  SYNC_NIBBLE = 4'hA;

   localparam logic [15:0] ID_TH_A = 16'h02D1;
   localparam logic [15:0] ID_TH_B = 16'h428F;
   localparam logic [15:0] ID_TH_C = 16'h4B8F;
   localparam logic [15:0] ID_T_A  = 16'h04CE;
   localparam logic [15:0] ID_T_B  = 16'h448C;

   localparam logic [4:0]  END_POS_UNKNOWN = 5'd8;
   localparam logic [4:0]  END_POS_TH      = 5'd18;
   localparam logic [4:0]  END_POS_T       = 5'd15;
   localparam logic [4:0]  SUM_END_UNKNOWN = 5'd8;
   localparam logic [4:0]  SUM_END_TH      = 5'd16;
   localparam logic [4:0]  SUM_END_T       = 5'd13;

   localparam logic        FUNC_CLEAR  = 1'b0;
   localparam logic        FUNC_NIBBLE = 1'b1;

   typedef enum logic [1:0] {
      LAYOUT_UNKNOWN = 2'd0,
      LAYOUT_TH      = 2'd1,
      LAYOUT_T       = 2'd2
   } layout_type;

   typedef struct packed {
      logic       func;
      logic [3:0] nibble;
      logic [4:0] position;
   } item_type;

   typedef struct packed {
      logic [15:0]        sensor_id;
      logic [3:0]         channel;
      logic [7:0]         rolling_code;
      logic [3:0]         flag_bits;
      logic signed [11:0] temperature_tenths;
      logic [7:0]         humidity;
      logic               sum_matches;
      logic               packet_complete;
      logic               sync_seen;
      logic               has_temp;
      logic               has_humid;
   } result_type;

   function automatic logic id_is_th(input logic [15:0] id);
      return (id == ID_TH_A) || (id == ID_TH_B) || (id == ID_TH_C);
   endfunction

   function automatic logic id_is_t(input logic [15:0] id);
      return (id == ID_T_A) || (id == ID_T_B);
   endfunction

   // Times ten and times one hundred, built from shifts of the digit.
   function automatic logic [11:0] times_ten(input logic [3:0] nib);
      return ({8'd0, nib} << 3) + ({8'd0, nib} << 1);
   endfunction

   function automatic logic [11:0] times_hundred(input logic [3:0] nib);
      return ({8'd0, nib} << 6) + ({8'd0, nib} << 5) + ({8'd0, nib} << 2);
   endfunction

endpackage

FILE: rtl/snd_state.sv
// Decoder state registers and the per-nibble update logic.
module snd_state (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  snd_pkg::item_type   item,
   output snd_pkg::result_type result
);

   logic                sync_ff,      sync_in;
   logic [15:0]         id_ff,        id_in;
   logic [3:0]          channel_ff,   channel_in;
   logic [7:0]          rolling_ff,   rolling_in;
   logic [3:0]          flags_ff,     flags_in;
   logic [7:0]          rx_sum_ff,    rx_sum_in;
   logic [7:0]          run_sum_ff,   run_sum_in;
   logic [11:0]         temp_ff,      temp_in;
   logic [7:0]          humid_ff,     humid_in;
   logic                done_ff,      done_in;
   snd_pkg::layout_type layout_ff,    layout_in;

   logic [4:0] end_pos;
   logic [4:0] sum_end;
   logic       is_th_layout;

   always_comb begin
      case (layout_ff)
         snd_pkg::LAYOUT_TH: begin
            end_pos = snd_pkg::END_POS_TH;
            sum_end = snd_pkg::SUM_END_TH;
         end
         snd_pkg::LAYOUT_T: begin
            end_pos = snd_pkg::END_POS_T;
            sum_end = snd_pkg::SUM_END_T;
         end
         default: begin
            end_pos = snd_pkg::END_POS_UNKNOWN;
            sum_end = snd_pkg::SUM_END_UNKNOWN;
         end
      endcase
   end

   assign is_th_layout = (layout_ff == snd_pkg::LAYOUT_TH);

   always_comb begin
      sync_in    = sync_ff;
      id_in      = id_ff;
      channel_in = channel_ff;
      rolling_in = rolling_ff;
      flags_in   = flags_ff;
      rx_sum_in  = rx_sum_ff;
      run_sum_in = run_sum_ff;
      temp_in    = temp_ff;
      humid_in   = humid_ff;
      done_in    = done_ff;
      layout_in  = layout_ff;

      if (item.func == snd_pkg::FUNC_CLEAR) begin
         sync_in    = 1'b0;
         id_in      = '0;
         channel_in = '0;
         rolling_in = '0;
         flags_in   = '0;
         rx_sum_in  = '0;
         run_sum_in = '0;
         temp_in    = '0;
         humid_in   = '0;
         done_in    = 1'b0;
         layout_in  = snd_pkg::LAYOUT_UNKNOWN;
      end else if (!done_ff && (item.position <= end_pos)) begin
         // The window uses the layout in force before this nibble was taken.
         if ((item.position != 5'd0) && (item.position < sum_end)) begin
            run_sum_in = run_sum_ff + {4'd0, item.nibble};
         end
         case (item.position)
            5'd0: sync_in = (item.nibble == snd_pkg::SYNC_NIBBLE);
            5'd1: id_in[3:0]   = id_ff[3:0]   | item.nibble;
            5'd2: id_in[7:4]   = id_ff[7:4]   | item.nibble;
            5'd3: id_in[11:8]  = id_ff[11:8]  | item.nibble;
            5'd4: id_in[15:12] = id_ff[15:12] | item.nibble;
            5'd5: begin
               if (snd_pkg::id_is_th(id_ff)) begin
                  layout_in = snd_pkg::LAYOUT_TH;
               end else if (snd_pkg::id_is_t(id_ff)) begin
                  layout_in = snd_pkg::LAYOUT_T;
               end
               channel_in = item.nibble;
            end
            5'd6: rolling_in[3:0] = rolling_ff[3:0] | item.nibble;
            5'd7: rolling_in[7:4] = rolling_ff[7:4] | item.nibble;
            5'd8: flags_in = item.nibble;
            5'd9:  temp_in = temp_ff + {8'd0, item.nibble};
            5'd10: temp_in = temp_ff + snd_pkg::times_ten(item.nibble);
            5'd11: temp_in = temp_ff + snd_pkg::times_hundred(item.nibble);
            5'd12: begin
               if (item.nibble != 4'd0) begin
                  temp_in = 12'd0 - temp_ff;
               end
            end
            5'd13: begin
               if (is_th_layout) begin
                  humid_in = humid_ff + {4'd0, item.nibble};
               end else begin
                  rx_sum_in[3:0] = rx_sum_ff[3:0] | item.nibble;
               end
            end
            5'd14: begin
               if (is_th_layout) begin
                  humid_in = humid_ff + 8'(snd_pkg::times_ten(item.nibble));
               end else begin
                  rx_sum_in[7:4] = rx_sum_ff[7:4] | item.nibble;
               end
            end
            5'd15: begin
               if (!is_th_layout) begin
                  done_in = 1'b1;
               end
            end
            5'd16: begin
               if (is_th_layout) begin
                  rx_sum_in[3:0] = rx_sum_ff[3:0] | item.nibble;
               end
            end
            5'd17: begin
               if (is_th_layout) begin
                  rx_sum_in[7:4] = rx_sum_ff[7:4] | item.nibble;
               end
            end
            5'd18: begin
               if (is_th_layout) begin
                  done_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= 1'b0;
         id_ff      <= '0;
         channel_ff <= '0;
         rolling_ff <= '0;
         flags_ff   <= '0;
         rx_sum_ff  <= '0;
         run_sum_ff <= '0;
         temp_ff    <= '0;
         humid_ff   <= '0;
         done_ff    <= 1'b0;
         layout_ff  <= snd_pkg::LAYOUT_UNKNOWN;
      end else if (advance) begin
         sync_ff    <= sync_in;
         id_ff      <= id_in;
         channel_ff <= channel_in;
         rolling_ff <= rolling_in;
         flags_ff   <= flags_in;
         rx_sum_ff  <= rx_sum_in;
         run_sum_ff <= run_sum_in;
         temp_ff    <= temp_in;
         humid_ff   <= humid_in;
         done_ff    <= done_in;
         layout_ff  <= layout_in;
      end
   end

   // The result reflects the state after this item.
   always_comb begin
      result.sensor_id          = id_in;
      result.channel            = channel_in;
      result.rolling_code       = rolling_in;
      result.flag_bits          = flags_in;
      result.temperature_tenths = signed'(temp_in);
      result.humidity           = humid_in;
      result.sum_matches        = (rx_sum_in == run_sum_in);
      result.packet_complete    = done_in;
      result.sync_seen          = sync_in;
      result.has_temp           = snd_pkg::id_is_th(id_in) || snd_pkg::id_is_t(id_in);
      result.has_humid          = snd_pkg::id_is_th(id_in);
   end

endmodule

FILE: rtl/sensor_packet_nibble_decoder.sv
// Path: an accepted item is held in the input register and then passes through the state
// update into the result register that drives rsp_, waiting there while rsp_stall holds it.
// Throughput: one item per cycle while rsp_stall does not hold the result; the single
// state-update stage lies between the input register and the result register.
// Reset: synchronous, active high; clears the decoder state and both valid flags,
// as if a clear item had been taken.
module sensor_packet_nibble_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [3:0]         req_nibble,
   input  logic [4:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_sensor_id,
   output logic [3:0]         rsp_channel,
   output logic [7:0]         rsp_rolling_code,
   output logic [3:0]         rsp_flag_bits,
   output logic signed [11:0] rsp_temperature_tenths,
   output logic [7:0]         rsp_humidity,
   output logic               rsp_sum_matches,
   output logic               rsp_packet_complete,
   output logic               rsp_sync_seen,
   output logic               rsp_has_temp,
   output logic               rsp_has_humid
);

   logic                in_valid_ff, in_valid_in;
   snd_pkg::item_type   in_item_ff;
   logic                out_valid_ff, out_valid_in;
   snd_pkg::result_type out_result_ff;
   snd_pkg::result_type next_result;
   logic                advance;
   logic                accept;

   // The held item moves on whenever the result register is free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.func     <= req_func;
         in_item_ff.nibble   <= req_nibble;
         in_item_ff.position <= req_position;
      end
      if (advance) begin
         out_result_ff <= next_result;
      end
   end

   snd_state u_state (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (next_result)
   );

   assign rsp_valid              = out_valid_ff;
   assign rsp_sensor_id          = out_result_ff.sensor_id;
   assign rsp_channel            = out_result_ff.channel;
   assign rsp_rolling_code       = out_result_ff.rolling_code;
   assign rsp_flag_bits          = out_result_ff.flag_bits;
   assign rsp_temperature_tenths = out_result_ff.temperature_tenths;
   assign rsp_humidity           = out_result_ff.humidity;
   assign rsp_sum_matches        = out_result_ff.sum_matches;
   assign rsp_packet_complete    = out_result_ff.packet_complete;
   assign rsp_sync_seen          = out_result_ff.sync_seen;
   assign rsp_has_temp           = out_result_ff.has_temp;
   assign rsp_has_humid          = out_result_ff.has_humid;

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

   assert property (@(posedge clock) disable iff (reset)
      (advance && (in_item_ff.func == snd_pkg::FUNC_CLEAR)) |=>
         (rsp_valid && !rsp_packet_complete && !rsp_sync_seen && (rsp_sensor_id == 16'd0)))
      else $error("clear item did not give a cleared result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_has_humid || rsp_has_temp))
      else $error("humidity layout flagged without temperature");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(out_result_ff) && !$past(advance)))
      else $error("held result changed while stalled");

endmodule

FILE: dv/tb_sensor_packet_nibble_decoder.sv
// Self-checking testbench for the sensor packet nibble decoder with a predicting scoreboard.
`timescale 1ns / 100ps

class nibble_decode_scoreboard;
   snd_pkg::result_type decoded_fields_q[$];
   int unsigned mismatches;

   logic                sync_q;
   logic [15:0]         id_q;
   logic [3:0]          chan_q;
   logic [7:0]          roll_q;
   logic [3:0]          flags_q;
   logic [7:0]          rx_sum_q;
   logic [7:0]          run_sum_q;
   logic [11:0]         temp_q;
   logic [7:0]          humid_q;
   logic                done_q;
   snd_pkg::layout_type layout_q;

   function new();
      mismatches = 0;
      clear_decoder();
   endfunction

   function void clear_decoder();
      sync_q    = 1'b0;
      id_q      = '0;
      chan_q    = '0;
      roll_q    = '0;
      flags_q   = '0;
      rx_sum_q  = '0;
      run_sum_q = '0;
      temp_q    = '0;
      humid_q   = '0;
      done_q    = 1'b0;
      layout_q  = snd_pkg::LAYOUT_UNKNOWN;
   endfunction

   function bit humid_sensor(logic [15:0] id);
      case (id)
         snd_pkg::ID_TH_A, snd_pkg::ID_TH_B, snd_pkg::ID_TH_C: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function bit temp_only_sensor(logic [15:0] id);
      case (id)
         snd_pkg::ID_T_A, snd_pkg::ID_T_B: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Weight of a BCD digit by its index within its group.
   function int digit_weight(int idx);
      if (idx == 0) return 1;
      if (idx == 1) return 10;
      return 100;
   endfunction

   function void decode_nibble(logic [3:0] nib, logic [4:0] pos);
      int p;
      int end_pos;
      int sum_end;
      p = pos;
      end_pos = snd_pkg::END_POS_UNKNOWN;
      sum_end = snd_pkg::SUM_END_UNKNOWN;
      if (layout_q == snd_pkg::LAYOUT_TH) begin
         end_pos = snd_pkg::END_POS_TH;
         sum_end = snd_pkg::SUM_END_TH;
      end else if (layout_q == snd_pkg::LAYOUT_T) begin
         end_pos = snd_pkg::END_POS_T;
         sum_end = snd_pkg::SUM_END_T;
      end
      if (done_q || p > end_pos) return;
      // The sum window uses the layout in force before this nibble is decoded.
      if (p > 0 && p < sum_end) run_sum_q = run_sum_q + 8'(nib);

      if (p == 0) begin
         sync_q = (nib == snd_pkg::SYNC_NIBBLE);
      end else if (p <= 4) begin
         id_q = id_q | (16'(nib) << ((p - 1) * 4));
      end else if (p == 5) begin
         if (humid_sensor(id_q)) layout_q = snd_pkg::LAYOUT_TH;
         else if (temp_only_sensor(id_q)) layout_q = snd_pkg::LAYOUT_T;
         chan_q = nib;
      end else if (p <= 7) begin
         roll_q = roll_q | (8'(nib) << ((p - 6) * 4));
      end else if (p == 8) begin
         flags_q = nib;
      end else if (p <= 11) begin
         temp_q = temp_q + 12'(int'(nib) * digit_weight(p - 9));
      end else if (p == 12) begin
         if (nib != 4'd0) temp_q = 12'd0 - temp_q;
      end else if (layout_q == snd_pkg::LAYOUT_TH) begin
         if (p <= 14) humid_q = humid_q + 8'(int'(nib) * digit_weight(p - 13));
         else if (p == 16 || p == 17) rx_sum_q = rx_sum_q | (8'(nib) << ((p - 16) * 4));
         else if (p == 18) done_q = 1'b1;
      end else begin
         if (p <= 14) rx_sum_q = rx_sum_q | (8'(nib) << ((p - 13) * 4));
         else if (p == 15) done_q = 1'b1;
      end
   endfunction

   function void note_item(logic func, logic [3:0] nib, logic [4:0] pos);
      snd_pkg::result_type fields;
      if (func == snd_pkg::FUNC_CLEAR) clear_decoder();
      else decode_nibble(nib, pos);
      fields.sensor_id          = id_q;
      fields.channel            = chan_q;
      fields.rolling_code       = roll_q;
      fields.flag_bits          = flags_q;
      fields.temperature_tenths = temp_q;
      fields.humidity           = humid_q;
      fields.sum_matches        = (rx_sum_q == run_sum_q);
      fields.packet_complete    = done_q;
      fields.sync_seen          = sync_q;
      fields.has_temp           = humid_sensor(id_q) || temp_only_sensor(id_q);
      fields.has_humid          = humid_sensor(id_q);
      decoded_fields_q.push_back(fields);
   endfunction

   function void compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function void check_item(snd_pkg::result_type got);
      snd_pkg::result_type want;
      if (decoded_fields_q.size() == 0) begin
         $error("result item arrived with no item outstanding");
         mismatches++;
         return;
      end
      want = decoded_fields_q.pop_front();
      compare_field("sensor_id", want.sensor_id, got.sensor_id);
      compare_field("channel", want.channel, got.channel);
      compare_field("rolling_code", want.rolling_code, got.rolling_code);
      compare_field("flag_bits", want.flag_bits, got.flag_bits);
      compare_field("temperature_tenths", want.temperature_tenths, got.temperature_tenths);
      compare_field("humidity", want.humidity, got.humidity);
      compare_field("sum_matches", want.sum_matches, got.sum_matches);
      compare_field("packet_complete", want.packet_complete, got.packet_complete);
      compare_field("sync_seen", want.sync_seen, got.sync_seen);
      compare_field("has_temp", want.has_temp, got.has_temp);
      compare_field("has_humid", want.has_humid, got.has_humid);
   endfunction

   function int pending();
      return decoded_fields_q.size();
   endfunction
endclass

module tb_sensor_packet_nibble_decoder;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_func = snd_pkg::FUNC_CLEAR;
   logic [3:0]         req_nibble = '0;
   logic [4:0]         req_position = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [15:0]        rsp_sensor_id;
   logic [3:0]         rsp_channel;
   logic [7:0]         rsp_rolling_code;
   logic [3:0]         rsp_flag_bits;
   logic signed [11:0] rsp_temperature_tenths;
   logic [7:0]         rsp_humidity;
   logic               rsp_sum_matches;
   logic               rsp_packet_complete;
   logic               rsp_sync_seen;
   logic               rsp_has_temp;
   logic               rsp_has_humid;

   nibble_decode_scoreboard board = new();

   int   items_sent = 0;
   int   send_idle_pct = 10;
   int   rsp_idle_pct = 63;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;

   sensor_packet_nibble_decoder u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_func               (req_func),
      .req_nibble             (req_nibble),
      .req_position           (req_position),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_sensor_id          (rsp_sensor_id),
      .rsp_channel            (rsp_channel),
      .rsp_rolling_code       (rsp_rolling_code),
      .rsp_flag_bits          (rsp_flag_bits),
      .rsp_temperature_tenths (rsp_temperature_tenths),
      .rsp_humidity           (rsp_humidity),
      .rsp_sum_matches        (rsp_sum_matches),
      .rsp_packet_complete    (rsp_packet_complete),
      .rsp_sync_seen          (rsp_sync_seen),
      .rsp_has_temp           (rsp_has_temp),
      .rsp_has_humid          (rsp_has_humid)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random stalls, plus a long hold whenever the main process flips hold_toggle.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : monitor
      snd_pkg::result_type seen;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen.sensor_id          = rsp_sensor_id;
            seen.channel            = rsp_channel;
            seen.rolling_code       = rsp_rolling_code;
            seen.flag_bits          = rsp_flag_bits;
            seen.temperature_tenths = rsp_temperature_tenths;
            seen.humidity           = rsp_humidity;
            seen.sum_matches        = rsp_sum_matches;
            seen.packet_complete    = rsp_packet_complete;
            seen.sync_seen          = rsp_sync_seen;
            seen.has_temp           = rsp_has_temp;
            seen.has_humid          = rsp_has_humid;
            board.check_item(seen);
         end
         if (req_valid && !req_stall) board.note_item(req_func, req_nibble, req_position);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_item(logic func, logic [3:0] nib, logic [4:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_nibble   <= nib;
      req_position <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_noise();
      send_item(($urandom_range(3) != 0) ? snd_pkg::FUNC_NIBBLE : snd_pkg::FUNC_CLEAR,
                4'($urandom), 5'($urandom));
   endtask

   // Stops offering items until every outstanding result item has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      @(posedge clock);
   endtask

   task automatic send_directed();
      logic [3:0] th_nib [0:18];
      // Humidity packet with extreme digits, negative sign and a correct checksum of 0x95.
      th_nib = '{4'hA, 4'hF, 4'h8, 4'h2, 4'h4, 4'hF, 4'h0, 4'hF, 4'hF, 4'h9,
                 4'h9, 4'h9, 4'hF, 4'h9, 4'h9, 4'hF, 4'h5, 4'h9, 4'hF};
      send_item(snd_pkg::FUNC_CLEAR, 4'hF, 5'd31);
      for (int k = 0; k < 19; k++) send_item(snd_pkg::FUNC_NIBBLE, th_nib[k], 5'(k));
      // After completion everything is ignored until a clear.
      send_item(snd_pkg::FUNC_NIBBLE, 4'h0, 5'd31);
      send_item(snd_pkg::FUNC_CLEAR, 4'h0, 5'd0);
      send_item(snd_pkg::FUNC_NIBBLE, 4'h0, 5'd0);
      // Past the end of the unknown layout.
      send_item(snd_pkg::FUNC_NIBBLE, 4'hF, 5'd9);
   endtask

   task automatic send_packet();
      logic [3:0]  pkt [0:18];
      logic [15:0] id;
      logic [7:0]  sum;
      int          kind;
      int          last;
      int          sum_end;
      int          r;
      kind = $urandom_range(99);
      if (kind < 40) begin
         case ($urandom_range(2))
            0: id = snd_pkg::ID_TH_A;
            1: id = snd_pkg::ID_TH_B;
            default: id = snd_pkg::ID_TH_C;
         endcase
         last = snd_pkg::END_POS_TH;
         sum_end = snd_pkg::SUM_END_TH;
      end else if (kind < 75) begin
         id = ($urandom_range(1) == 0) ? snd_pkg::ID_T_A : snd_pkg::ID_T_B;
         last = snd_pkg::END_POS_T;
         sum_end = snd_pkg::SUM_END_T;
      end else begin
         id = 16'($urandom);
         last = $urandom_range(8, 12);
         sum_end = snd_pkg::SUM_END_UNKNOWN;
      end
      for (int k = 0; k <= 18; k++) pkt[k] = 4'($urandom);
      if ($urandom_range(9) != 0) pkt[0] = snd_pkg::SYNC_NIBBLE;
      for (int k = 1; k <= 4; k++) pkt[k] = id[4*(k-1) +: 4];
      for (int k = 9; k <= 14; k++) begin
         if ($urandom_range(9) != 0) pkt[k] = 4'($urandom_range(9));
      end
      if ($urandom_range(1) == 0) pkt[12] = 4'd0;
      sum = '0;
      for (int k = 1; k < sum_end; k++) sum = sum + 8'(pkt[k]);
      if (sum_end != snd_pkg::SUM_END_UNKNOWN && $urandom_range(6) != 0) begin
         pkt[sum_end]     = sum[3:0];
         pkt[sum_end + 1] = sum[7:4];
      end

      if ($urandom_range(9) != 0) send_item(snd_pkg::FUNC_CLEAR, 4'($urandom), 5'($urandom));
      for (int k = 0; k <= last; k++) begin
         r = $urandom_range(99);
         if (r < 3) begin
            send_item(snd_pkg::FUNC_CLEAR, 4'($urandom), 5'($urandom));
         end else if (r < 7) begin
            // Revisit an earlier position, which also exercises a changed id at position 5.
            send_item(snd_pkg::FUNC_NIBBLE, 4'($urandom), 5'($urandom_range(0, k)));
         end else if (r < 10) begin
            send_noise();
         end
         send_item(snd_pkg::FUNC_NIBBLE, pkt[k], 5'(k));
      end
      if ($urandom_range(3) == 0) send_item(snd_pkg::FUNC_NIBBLE, 4'($urandom), 5'($urandom));
   endtask

   task automatic send_random_until(int target);
      while (items_sent < target) begin
         if ($urandom_range(99) < 85) begin
            send_packet();
         end else begin
            repeat ($urandom_range(1, 4)) send_noise();
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      drain();
      send_random_until(600);
      drain();

      send_idle_pct = 63;
      rsp_idle_pct <= 10;
      send_random_until(1200);
      drain();

      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      // Long receiver hold while items keep coming, so the input side backs up.
      hold_toggle <= ~hold_toggle;
      send_random_until(1780);

      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
